// ===== rtl/interval_room_partitioner_top_defines.svh =====
// Assertion macros for the interval room partitioner.
// Each macro asserts a property on the rising edge of clk with rst masking it.
`ifndef INTERVAL_ROOM_PARTITIONER_TOP_DEFINES_SVH
`define INTERVAL_ROOM_PARTITIONER_TOP_DEFINES_SVH
`ifndef SYNTH
`define IRP_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IRP_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);
`else
`define IRP_ASSERT_NOW(label, prop, msg)
`define IRP_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

// ===== rtl/irp_pkg.sv =====
package irp_pkg;

  localparam int DATA_W             = 32;
  localparam int ROOM_COUNT_W       = 9;
  localparam int IN_TDATA_W         = 64;
  localparam int OUT_TDATA_W        = 16;
  localparam int DEF_MAX_INTERVALS  = 256;
  localparam int DEF_TIME_WIDTH     = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the accepted beat
    logic scan_init;  // restart the minimum search
    logic scan_run;   // one step of the minimum search
    logic take;       // mark the chosen interval and restart the room search
    logic room_run;   // one step of the first-fit room search
    logic place;      // write the room end time
    logic clear;      // hand the result over and empty the set
  } irp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic room_done;
    logic last_pick;
  } irp_stat_t;

endpackage

// ===== rtl/interval_room_partitioner_top.sv =====
// Interval room partitioner. Each beat on the slave stream carries one interval
// (start and end time, signed). Intervals are stored one per cycle, up to
// MAX_INTERVALS of them; further ones are dropped and flagged as overflow. The beat
// with tlast set ends the set and starts the greedy pass: the pass repeatedly picks
// the remaining interval with the smallest start (the earliest stored on a tie) and
// places it in the lowest-numbered room whose end time is at most that start, or
// opens a new room. One result beat then gives the room count and the overflow flag,
// and the block is empty again. The length of the pass is set by the interval store,
// which is searched one entry per cycle through its single read port for every
// pick, followed by a one-room-per-cycle search of the room store. The slave side
// is not ready while the pass runs, nor while a finished result waits for a full
// output register. The result sits in an output register, so loading of the next
// set can begin while it waits to be taken. All stores are written before they are
// read within a set, so no clearing pass follows reset.
`include "interval_room_partitioner_top_defines.svh"

module interval_room_partitioner_top
  import irp_pkg::*;
#(
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int TIME_WIDTH    = DEF_TIME_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // Interval beats. tdata: span_start [31:0], span_stop [63:32].
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  // Result beats. tdata: room_count [8:0], overflow [9], zeros [15:10].
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  irp_cmd_t                cmd;
  irp_stat_t               stat;
  logic [ROOM_COUNT_W-1:0] room_count;
  logic                    overflow;
  logic                    out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  irp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  irp_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .span_start (s_axis_tdata[DATA_W-1:0]),
    .span_stop  (s_axis_tdata[2*DATA_W-1:DATA_W]),
    .stat       (stat),
    .room_count (room_count),
    .overflow   (overflow)
  );

  // Result register. The controller clears the set in the same cycle that the
  // result is captured here, so the captured values are those of the finished pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.clear) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      m_axis_tdata <= {(OUT_TDATA_W - ROOM_COUNT_W - 1)'(0), overflow, room_count};
    end
  end

  // The beat that ends a set always starts the pass, which holds off new beats.
  `IRP_ASSERT_NEXT(a_last_starts_pass, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input still ready after the last beat of a set")
  // A result is produced only at the end of a pass, while the input is held off.
  `IRP_ASSERT_NOW(a_result_after_pass, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared without a pass")

endmodule

// ===== rtl/irp_ctrl.sv =====
module irp_ctrl
  import irp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  input  logic      out_free,
  input  irp_stat_t stat,
  output logic      in_ready,
  output irp_cmd_t  cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_TAKE  = 3'd2;
  localparam logic [2:0] S_ROOM  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.take   = 1'b1;
        state_next = S_ROOM;
      end
      S_ROOM: begin
        cmd.room_run = 1'b1;
        if (stat.room_done) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        if (stat.last_pick) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/irp_dp.sv =====
module irp_dp
  import irp_pkg::*;
#(
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int TIME_WIDTH    = DEF_TIME_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  irp_cmd_t                cmd,
  input  logic [DATA_W-1:0]       span_start,
  input  logic [DATA_W-1:0]       span_stop,
  output irp_stat_t               stat,
  output logic [ROOM_COUNT_W-1:0] room_count,
  output logic                    overflow
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

  // Times are kept as order-preserving unsigned keys: sign bit flipped.
  logic [TIME_WIDTH-1:0] start_mem [MAX_INTERVALS];
  logic [TIME_WIDTH-1:0] end_mem   [MAX_INTERVALS];
  logic                  taken_mem [MAX_INTERVALS];
  logic [TIME_WIDTH-1:0] room_mem  [MAX_INTERVALS];

  logic [TIME_WIDTH-1:0] start_q;
  logic [TIME_WIDTH-1:0] end_q;
  logic                  taken_q;
  logic [TIME_WIDTH-1:0] room_q;

  logic [CNT_W-1:0]      loaded_count;
  logic                  overflow_seen;
  logic [CNT_W-1:0]      rooms;
  logic [CNT_W-1:0]      picks;

  logic [CNT_W-1:0]      scan_ptr;
  logic                  scan_pend;
  logic [IDX_W-1:0]      scan_idx;
  logic                  found;
  logic [TIME_WIDTH-1:0] best;
  logic [IDX_W-1:0]      pick;

  logic [CNT_W-1:0]      room_ptr;
  logic                  room_pend;
  logic [IDX_W-1:0]      room_idx;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;

  logic signed [63:0]    start_ext;
  logic signed [63:0]    end_ext;
  logic [TIME_WIDTH-1:0] start_key;
  logic [TIME_WIDTH-1:0] end_key;
  logic                  full;
  logic [IDX_W-1:0]      load_idx;
  logic                  scan_issue;
  logic                  room_issue;
  logic [IDX_W-1:0]      place_idx;

  assign start_ext = 64'(signed'(span_start));
  assign end_ext   = 64'(signed'(span_stop));
  assign start_key = {~start_ext[TIME_WIDTH-1], start_ext[TIME_WIDTH-2:0]};
  assign end_key   = {~end_ext[TIME_WIDTH-1], end_ext[TIME_WIDTH-2:0]};

  assign full       = (loaded_count == CNT_MAX);
  assign load_idx   = loaded_count[IDX_W-1:0];
  assign scan_issue = (scan_ptr < loaded_count);
  assign room_issue = (room_ptr < rooms) && !hit;
  assign place_idx  = hit ? hit_idx : rooms[IDX_W-1:0];

  // Interval stores.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      start_mem[load_idx] <= start_key;
      end_mem[load_idx]   <= end_key;
    end
    start_q <= start_mem[scan_ptr[IDX_W-1:0]];
    end_q   <= end_mem[pick];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      taken_mem[load_idx] <= 1'b0;
    end else if (cmd.take) begin
      taken_mem[pick] <= 1'b1;
    end
    taken_q <= taken_mem[scan_ptr[IDX_W-1:0]];
  end

  // Room end times.
  always_ff @(posedge clk) begin
    if (cmd.place) begin
      room_mem[place_idx] <= end_q;
    end
    room_q <= room_mem[room_ptr[IDX_W-1:0]];
  end

  // Set bookkeeping.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
      rooms         <= '0;
      picks         <= '0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          loaded_count <= loaded_count + 1'b1;
        end
      end
      if (cmd.place) begin
        picks <= picks + 1'b1;
        if (!hit) begin
          rooms <= rooms + 1'b1;
        end
      end
    end
  end

  // Minimum-start search, one entry per cycle; strict compare keeps the earliest.
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      scan_ptr  <= '0;
      scan_pend <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.scan_run) begin
      if (scan_issue) begin
        scan_ptr <= scan_ptr + 1'b1;
      end
      scan_pend <= scan_issue;
      scan_idx  <= scan_ptr[IDX_W-1:0];
      if (scan_pend && !taken_q && (!found || start_q < best)) begin
        found <= 1'b1;
        best  <= start_q;
        pick  <= scan_idx;
      end
    end
  end

  // First-fit room search, stops at the first room that has ended.
  always_ff @(posedge clk) begin
    if (rst || cmd.take) begin
      room_ptr  <= '0;
      room_pend <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.room_run) begin
      if (room_issue) begin
        room_ptr <= room_ptr + 1'b1;
      end
      room_pend <= room_issue;
      room_idx  <= room_ptr[IDX_W-1:0];
      if (room_pend && !hit && room_q <= best) begin
        hit     <= 1'b1;
        hit_idx <= room_idx;
      end
    end
  end

  assign stat.scan_done = (scan_ptr == loaded_count) && !scan_pend;
  assign stat.room_done = (hit || room_ptr == rooms) && !room_pend;
  assign stat.last_pick = ({1'b0, picks} + 1'b1) == {1'b0, loaded_count};

  assign room_count = ROOM_COUNT_W'(rooms);
  assign overflow   = overflow_seen;

endmodule

// ===== tb/tb_interval_room_partitioner_top.sv =====
`timescale 1ns / 1ps

// Testbench for the interval room partitioner. Interval beats are pushed
// into the slave stream in sets, each closed by a beat with tlast set. A
// scoreboard keeps its own copy of the interval store and runs the greedy
// first-fit pass on every closed set. Result beats on the master stream are
// compared against the oldest prediction, field by field.
module tb_interval_room_partitioner_top;
  import irp_pkg::*;

  localparam int CAP         = DEF_MAX_INTERVALS;
  localparam int TIME_W      = DEF_TIME_WIDTH;
  // The longest pass (a full store, every interval in a room of its own)
  // stays well below this limit, which leaves a wide margin.
  localparam int STALL_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PRESSURE_HOLD = 1000;
  localparam int PHASE_BEATS = 330;

  localparam logic [DATA_W-1:0] T_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] T_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [ROOM_COUNT_W-1:0] rooms;
    logic                    overflow;
  } room_result_t;

  // Scoreboard: mirrors the interval store and predicts the room count.
  class partition_checker;
    logic signed [TIME_W-1:0] starts[CAP];
    logic signed [TIME_W-1:0] ends[CAP];
    int unsigned  loaded;
    bit           dropped;
    room_result_t rooms_due[$];
    int unsigned  errors;
    int unsigned  shown;

    function new();
      loaded  = 0;
      dropped = 0;
      errors  = 0;
      shown   = 0;
    endfunction

    // Greedy pass: smallest start first (earliest stored on a tie), placed
    // in the lowest room whose end time is not after that start.
    function int unsigned count_rooms();
      bit                       taken[CAP];
      logic signed [TIME_W-1:0] room_end[CAP];
      logic signed [TIME_W-1:0] best;
      int unsigned              rooms;
      int unsigned              pick;
      bit                       found;
      bit                       placed;
      rooms = 0;
      pick  = 0;
      best  = '0;
      foreach (taken[k]) taken[k] = 1'b0;
      for (int unsigned n = 0; n < loaded; n++) begin
        found = 1'b0;
        for (int unsigned j = 0; j < loaded; j++) begin
          if (!taken[j] && (!found || starts[j] < best)) begin
            found = 1'b1;
            best  = starts[j];
            pick  = j;
          end
        end
        taken[pick] = 1'b1;
        placed = 1'b0;
        for (int unsigned r = 0; r < rooms; r++) begin
          if (!placed && room_end[r] <= best) begin
            room_end[r] = ends[pick];
            placed = 1'b1;
          end
        end
        if (!placed) begin
          room_end[rooms] = ends[pick];
          rooms++;
        end
      end
      return rooms;
    endfunction

    function void note_interval(logic signed [DATA_W-1:0] s, logic signed [DATA_W-1:0] e,
                                logic last);
      room_result_t res;
      if (loaded < CAP) begin
        starts[loaded] = s;
        ends[loaded]   = e;
        loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        res.rooms    = ROOM_COUNT_W'(count_rooms());
        res.overflow = dropped;
        rooms_due.push_back(res);
        loaded  = 0;
        dropped = 1'b0;
      end
    endfunction

    function void check_rooms(logic [OUT_TDATA_W-1:0] beat);
      room_result_t want;
      logic [ROOM_COUNT_W-1:0] got_rooms;
      logic got_ovf;
      got_rooms = beat[ROOM_COUNT_W-1:0];
      got_ovf   = beat[ROOM_COUNT_W];
      if (rooms_due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result beat: rooms %0d overflow %0d", got_rooms, got_ovf);
        end
        return;
      end
      want = rooms_due.pop_front();
      if (got_rooms !== want.rooms || got_ovf !== want.overflow) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("result mismatch: rooms %0d overflow %0d, wanted rooms %0d overflow %0d",
                   got_rooms, got_ovf, want.rooms, want.overflow);
        end
      end
    endfunction

    function int unsigned pending();
      return rooms_due.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // span_start [31:0], span_stop [63:32]
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // room_count [8:0], overflow [9], zeros above

  partition_checker tally = new();

  // Idle and stall rates, in percent, changed from phase to phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_sent = 0;

  // Each bump of pressure_seq asks the receiver process for one long hold-off.
  int unsigned pressure_seq = 0;
  int unsigned pressure_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  interval_room_partitioner_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request so that the
  // output register stays full and the block has to back up its input.
  always @(posedge clk) begin
    if (pressure_seq != pressure_seen) begin
      pressure_seen = pressure_seq;
      hold_left = PRESSURE_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Both streams are observed at the clock edge, so the values seen are the
  // ones the design itself sampled.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tally.note_interval(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tally.check_rooms(m_axis_tdata);
      end
    end
  end

  // Watchdog: a run of cycles with no beat on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one interval beat after a random number of idle cycles and holds
  // it until the block takes it.
  task automatic send_interval(input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] e,
                               input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e, s};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic [DATA_W-1:0] extreme_time();
    case ($urandom_range(0, 5))
      0: return T_MIN;
      1: return T_MAX;
      2: return T_MIN + 1;
      3: return T_MAX - 1;
      4: return '0;
      default: return '1;
    endcase
  endfunction

  // Sets come in three flavors. Most keep all times in a narrow window so
  // that intervals overlap, touch and tie; some use fully random times; the
  // rest mix in the extremes and intervals that end before they start.
  task automatic send_random_set(input int unsigned n);
    int unsigned flavor;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] e;
    flavor = $urandom_range(0, 9);
    base = ($urandom_range(0, 9) == 0) ? extreme_time() - 32'd20
                                        : 32'($urandom_range(0, 2000)) - 32'd1000;
    for (int unsigned i = 0; i < n; i++) begin
      if (flavor <= 5) begin
        s = base + $urandom_range(0, 4 * n + 4);
        e = ($urandom_range(0, 9) == 0) ? s - $urandom_range(1, 5) : s + $urandom_range(0, 15);
      end else if (flavor <= 7) begin
        s = $urandom;
        e = $urandom;
      end else begin
        case ($urandom_range(0, 2))
          0: s = extreme_time();
          1: s = $urandom;
          default: s = base + $urandom_range(0, 30);
        endcase
        case ($urandom_range(0, 2))
          0: e = extreme_time();
          1: e = $urandom;
          default: e = s + $urandom_range(0, 10);
        endcase
      end
      send_interval(s, e, i == n - 1);
    end
  endtask

  task automatic run_random(input int unsigned beats);
    int unsigned stop_at;
    int unsigned n;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_set(n);
    end
  endtask

  // Withdraws the beat that was just taken so that it is not offered again,
  // lets it reach the scoreboard, then waits for every predicted result.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    @(posedge clk);
    while (tally.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase with no idling on either side: directed sets first.
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Single intervals spanning the whole range, one of them starting at
    // the largest time.
    send_interval(T_MIN, T_MAX, 1'b1);
    send_interval(T_MAX, T_MIN, 1'b1);
    // Ties at the largest start still get picked, in load order.
    send_interval(T_MAX, T_MAX, 1'b0);
    send_interval(T_MAX, T_MAX, 1'b0);
    send_interval(T_MIN, T_MIN, 1'b1);
    // Intervals that touch share one room.
    send_interval(32'd0, 32'd10, 1'b0);
    send_interval(32'd10, 32'd20, 1'b0);
    send_interval(32'd20, 32'd30, 1'b1);
    // Overlaps that force new rooms, then a reuse of the first room.
    send_interval(32'd0, 32'd10, 1'b0);
    send_interval(32'd5, 32'd15, 1'b0);
    send_interval(32'd9, 32'd12, 1'b0);
    send_interval(32'd12, 32'd20, 1'b1);
    // Negative times loaded out of order.
    send_interval(-32'sd5, -32'sd1, 1'b0);
    send_interval(-32'sd100, -32'sd50, 1'b0);
    send_interval(-32'sd50, -32'sd5, 1'b0);
    send_interval(-32'sd1, 32'd7, 1'b1);
    // Equal starts with different ends.
    send_interval(32'd3, 32'd100, 1'b0);
    send_interval(32'd3, 32'd4, 1'b0);
    send_interval(32'd4, 32'd5, 1'b0);
    send_interval(32'd100, 32'd101, 1'b1);
    // An interval that ends before it starts.
    send_interval(32'd10, 32'd0, 1'b0);
    send_interval(32'd0, 32'd5, 1'b1);

    // A full store where no interval fits an open room: 256 rooms.
    for (int i = 0; i < CAP; i++) begin
      send_interval(32'(i) - 32'd128, T_MAX, i == CAP - 1);
    end

    run_random(PHASE_BEATS);
    wait_results();

    // Sender idle most of the time.
    send_idle_pct  = 65;
    recv_stall_pct = 0;
    run_random(PHASE_BEATS);
    wait_results();

    // Long receiver hold-off while the sender keeps pushing short sets.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_seq++;
    for (int k = 0; k < 30; k++) begin
      send_random_set($urandom_range(1, 3));
    end
    wait_results();

    // Receiver stalling most of the time.
    send_idle_pct  = 0;
    recv_stall_pct = 65;
    run_random(PHASE_BEATS);
    wait_results();

    // Both sides idling; one set runs past the store capacity, its last
    // beat among the dropped ones.
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    for (int i = 0; i < CAP + 3; i++) begin
      send_interval(32'($urandom_range(0, 600)) - 32'd300, 32'($urandom_range(0, 600)),
                    i == CAP + 2);
    end
    run_random(PHASE_BEATS);

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
